### src/mfd_pkg.sv
// Package with the request types, parse phases and result codes of the MQTT frame deframer.
`default_nettype none
package mfd_pkg;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_BODY,
        PH_BADPUB
    } phase_t;

    localparam logic [2:0] CLS_TOPIC_LEN = 3'd0;
    localparam logic [2:0] CLS_TOPIC     = 3'd1;
    localparam logic [2:0] CLS_PACKET_ID = 3'd2;
    localparam logic [2:0] CLS_PAYLOAD   = 3'd3;
    localparam logic [2:0] CLS_OTHER     = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_PUB = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    localparam logic [3:0]  PUBLISH_NIBBLE    = 4'h3;
    localparam logic [15:0] HELD_MAX          = 16'hFFFF;
    localparam logic [15:0] TOPIC_LEN_RESET   = 16'd159;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic        chunk_start;
        logic [15:0] chunk_length;
    } in_req_t;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [27:0] remaining_length;
        logic [1:0]  qos_level;
        logic [7:0]  data_byte;
        logic        has_data;
        logic [2:0]  byte_class;
        logic        frame_end;
        logic [1:0]  status;
    } out_req_t;

endpackage
`default_nettype wire

### src/mfd_parser.sv
// Front end: accepts received bytes, tracks the frame and classifies each byte.
`default_nettype none
module mfd_parser #(
    parameter int BUFFER_BYTES = 1024
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mfd_pkg::in_req_t  in_req,
    input  wire logic [15:0]       max_topic_length,
    input  wire logic              q_full,
    output logic                   push,
    output mfd_pkg::out_req_t      push_req
);

    localparam logic [15:0] BUF_W = 16'(BUFFER_BYTES);

    mfd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [27:0] len_reg, len_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [27:0] pos_reg, pos_next;
    logic [15:0] topic_reg, topic_next;
    logic [15:0] held_reg, held_next;
    logic        discard_reg, discard_next;

    logic        fire;
    logic        is_pub;
    logic [1:0]  qos;
    logic [27:0] acc_new;
    logic [27:0] shifted;
    logic [15:0] tl_new;
    logic [27:0] need;
    logic        body_end;
    logic        overflow;
    logic [7:0]  b;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign b        = in_req.byte_value;
    assign is_pub   = (type_reg[7:4] == mfd_pkg::PUBLISH_NIBBLE);
    assign qos      = is_pub ? type_reg[2:1] : 2'd0;
    assign overflow = (held_reg >= BUF_W) || (in_req.chunk_length > (BUF_W - held_reg));
    assign body_end = ({1'b0, pos_reg} + 29'd1) >= {1'b0, len_reg};
    assign tl_new   = {topic_reg[15:8], b};
    assign need     = 28'(tl_new) + ((qos != 2'd0) ? 28'd4 : 28'd2);

    always_comb begin
        case (cnt_reg)
            2'd0:    shifted = 28'(b[6:0]);
            2'd1:    shifted = 28'(b[6:0]) << 7;
            2'd2:    shifted = 28'(b[6:0]) << 14;
            default: shifted = 28'(b[6:0]) << 21;
        endcase
        acc_new = len_reg | shifted;
    end

    always_comb begin
        logic clear;
        clear        = 1'b0;
        phase_next   = phase_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        topic_next   = topic_reg;
        held_next    = held_reg;
        discard_next = discard_reg;
        push         = 1'b0;
        push_req.frame_type       = type_reg;
        push_req.remaining_length = len_reg;
        push_req.qos_level        = qos;
        push_req.data_byte        = 8'd0;
        push_req.has_data         = 1'b0;
        push_req.byte_class       = mfd_pkg::CLS_OTHER;
        push_req.frame_end        = 1'b0;
        push_req.status           = mfd_pkg::ST_OK;

        if (fire) begin
            if (in_req.chunk_start && overflow) begin
                push               = 1'b1;
                push_req.frame_end = 1'b1;
                push_req.status    = mfd_pkg::ST_DROPPED;
                clear              = 1'b1;
                discard_next       = 1'b1;
            end else if (discard_reg && !in_req.chunk_start) begin
                discard_next = 1'b1;
            end else begin
                discard_next = 1'b0;
                if (held_reg != mfd_pkg::HELD_MAX) begin
                    held_next = held_reg + 16'd1;
                end
                case (phase_reg)
                    mfd_pkg::PH_TYPE: begin
                        type_next  = b;
                        len_next   = 28'd0;
                        cnt_next   = 2'd0;
                        pos_next   = 28'd0;
                        phase_next = mfd_pkg::PH_LEN;
                    end
                    mfd_pkg::PH_LEN: begin
                        len_next = acc_new;
                        cnt_next = cnt_reg + 2'd1;
                        push_req.remaining_length = acc_new;
                        if (b[7]) begin
                            if (cnt_reg == 2'd3) begin
                                push               = 1'b1;
                                push_req.frame_end = 1'b1;
                                push_req.status    = mfd_pkg::ST_BAD_LEN;
                                clear              = 1'b1;
                                discard_next       = 1'b1;
                            end
                        end else if (is_pub && acc_new < 28'd2) begin
                            phase_next         = mfd_pkg::PH_BADPUB;
                            push               = 1'b1;
                            push_req.status    = mfd_pkg::ST_BAD_PUB;
                            push_req.frame_end = (acc_new == 28'd0);
                            clear              = (acc_new == 28'd0);
                        end else begin
                            phase_next = mfd_pkg::PH_BODY;
                            if (acc_new == 28'd0) begin
                                push               = 1'b1;
                                push_req.frame_end = 1'b1;
                                clear              = 1'b1;
                            end
                        end
                    end
                    default: begin
                        push               = 1'b1;
                        push_req.data_byte = b;
                        push_req.has_data  = 1'b1;
                        push_req.frame_end = body_end;
                        if (phase_reg == mfd_pkg::PH_BADPUB) begin
                            push_req.status = mfd_pkg::ST_BAD_PUB;
                        end else if (is_pub) begin
                            if (pos_reg == 28'd0) begin
                                topic_next          = {b, 8'h00};
                                push_req.byte_class = mfd_pkg::CLS_TOPIC_LEN;
                            end else if (pos_reg == 28'd1) begin
                                topic_next          = tl_new;
                                push_req.byte_class = mfd_pkg::CLS_TOPIC_LEN;
                                if (tl_new == 16'd0 || tl_new > max_topic_length
                                        || need > len_reg) begin
                                    push_req.status = mfd_pkg::ST_BAD_PUB;
                                    phase_next      = mfd_pkg::PH_BADPUB;
                                end
                            end else if (pos_reg < 28'(topic_reg) + 28'd2) begin
                                push_req.byte_class = mfd_pkg::CLS_TOPIC;
                            end else if (qos != 2'd0 && pos_reg < 28'(topic_reg) + 28'd4) begin
                                push_req.byte_class = mfd_pkg::CLS_PACKET_ID;
                            end else begin
                                push_req.byte_class = mfd_pkg::CLS_PAYLOAD;
                            end
                        end else begin
                            push_req.byte_class = mfd_pkg::CLS_OTHER;
                        end
                        pos_next = pos_reg + 28'd1;
                        clear    = body_end;
                    end
                endcase
            end
            if (clear) begin
                phase_next = mfd_pkg::PH_TYPE;
                type_next  = 8'd0;
                len_next   = 28'd0;
                cnt_next   = 2'd0;
                pos_next   = 28'd0;
                topic_next = 16'd0;
                held_next  = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= mfd_pkg::PH_TYPE;
            type_reg    <= 8'd0;
            len_reg     <= 28'd0;
            cnt_reg     <= 2'd0;
            pos_reg     <= 28'd0;
            topic_reg   <= 16'd0;
            held_reg    <= 16'd0;
            discard_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            type_reg    <= type_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            pos_reg     <= pos_next;
            topic_reg   <= topic_next;
            held_reg    <= held_next;
            discard_reg <= discard_next;
        end
    end

endmodule
`default_nettype wire

### src/mfd_queue.sv
// Back end: short result queue that drives the result channel.
`default_nettype none
module mfd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire mfd_pkg::out_req_t  push_req,
    output logic                    full,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mfd_pkg::out_req_t       out_req
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    mfd_pkg::out_req_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pop;
    logic          wr;

    assign full      = (count_reg == FULL_COUNT);
    assign out_valid = (count_reg != '0);
    assign out_req   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr        = push && !full;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (wr && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) begin
            mem[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### src/mqtt_frame_deframer_top.sv
// Top level of the MQTT frame deframer: parser front end and result queue.
//
//   Channel   Ports                          Direction  Request
//   input     s_valid s_ready s_data         in         one received byte with chunk marks
//   result    m_valid m_ready m_data         out        one classified byte or frame event
//   config    cfg_valid cfg_ready cfg_data   in         max_topic_length write
//
// One byte is accepted per cycle while the result queue is not full; any result it yields
// enters the queue in the same cycle and can leave it on the next cycle.
// The parser takes a byte whenever the result queue has a free slot, so a stall on
// the result side only stops input once QUEUE_DEPTH results are waiting.
// Reset is synchronous and active low and needs no clearing pass.
`default_nettype none
module mqtt_frame_deframer_top #(
    parameter int BUFFER_BYTES = 1024,
    parameter int QUEUE_DEPTH  = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire mfd_pkg::in_req_t   s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output mfd_pkg::out_req_t       m_data,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data
);

    logic [15:0]       max_topic_reg;
    logic              q_full;
    logic              push;
    mfd_pkg::out_req_t push_req;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_topic_reg <= mfd_pkg::TOPIC_LEN_RESET;
        end else if (cfg_valid) begin
            max_topic_reg <= cfg_data;
        end
    end

    mfd_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_valid),
        .in_ready        (s_ready),
        .in_req          (s_data),
        .max_topic_length(max_topic_reg),
        .q_full          (q_full),
        .push            (push),
        .push_req        (push_req)
    );

    mfd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .full     (q_full),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_req  (m_data)
    );

endmodule
`default_nettype wire
